@@ rtl/ddmr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmr_pkg
// Shared types and constants of the differential drive mixer with ramping.
// ----------------------------------------------------------------------------
package ddmr_pkg;

    localparam int MAX_ELAPSED_MS = 100;
    localparam int MS_W           = $clog2(MAX_ELAPSED_MS + 1);
    localparam int STEP_W         = 15 + MS_W;
    localparam int DIV_STEPS      = 15;
    localparam int CNT_W          = $clog2(DIV_STEPS + 1);

    localparam logic [15:0] Q_ONE = 16'd32768;
    localparam logic [14:0] Q_MAX = 15'd32767;

    // Input operation codes.
    localparam logic [1:0] OP_TANK   = 2'd0;
    localparam logic [1:0] OP_ARCADE = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [2:0] REG_DEADZONE    = 3'd1;
    localparam logic [2:0] REG_RAMP_ENABLE = 3'd2;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd3;
    localparam logic [2:0] REG_INV_LEFT    = 3'd4;
    localparam logic [2:0] REG_INV_RIGHT   = 3'd5;

    typedef enum logic [2:0] {
        LANE_NOP,
        LANE_DZ,
        LANE_NORM,
        LANE_FIN,
        LANE_TICK,
        LANE_STOP
    } lane_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DZ_WAIT,
        S_NORM,
        S_NORM_WAIT,
        S_DZ2,
        S_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        lane_op_t            op;
        logic signed [17:0]  x;
        logic [16:0]         mx;
        logic [STEP_W-1:0]   step;
        logic [14:0]         dz;
        logic [15:0]         sl;
        logic                inv;
        logic                ramp;
    } lane_cmd_t;

    typedef struct packed {
        logic                busy;
        logic signed [17:0]  val;
        logic signed [15:0]  cur;
    } lane_stat_t;

    typedef struct packed {
        logic signed [17:0]  sum;
        logic signed [17:0]  diff;
        logic [16:0]         mx;
    } merge_t;

endpackage

@@ rtl/differential_drive_mixer_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_mixer_ramp
// Two-wheel tank/arcade drive mixer with deadzone, speed limit and slew ramp.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Left and right sides run in two lanes
// side by side, each with its own 15-step restoring divider. A tank command
// makes one deadzone pass; an arcade command makes three divider passes in a
// row (deadzone, normalize, deadzone again). The output register holds a
// finished item while the next item is taken in, so a stalled output only
// blocks the block when a second result is ready to leave.
module differential_drive_mixer_ramp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [15:0] value_a,
    input  logic signed [15:0] value_b,
    input  logic [15:0]        elapsed_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] right_drive,
    output logic signed [15:0] left_drive_negated,
    output logic               motors_off,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Configuration registers.
    logic [15:0] sl_reg;
    logic [14:0] dz_reg;
    logic        ramp_reg;
    logic [14:0] rs_reg;
    logic        invl_reg;
    logic        invr_reg;

    // Captured item.
    logic [1:0]         op_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic [15:0]        ms_reg;

    ddmr_pkg::state_t state_reg, state_next;
    logic second_reg, second_next;

    logic               ov_reg, ov_next;
    logic signed [15:0] rd_reg;
    logic signed [15:0] ln_reg;
    logic               off_reg;

    ddmr_pkg::lane_cmd_t  cmd_l, cmd_r;
    ddmr_pkg::lane_stat_t stat_l, stat_r;
    ddmr_pkg::merge_t     mix;

    logic                          accept;
    logic                          slot_free;
    logic                          lanes_idle;
    logic [ddmr_pkg::MS_W-1:0]     ms_c;
    logic [ddmr_pkg::STEP_W-1:0]   step;
    logic [15:0]                   sl_eff;
    logic                          load_out;

    assign accept     = in_valid && in_ready;
    assign slot_free  = !ov_reg || out_ready;
    assign lanes_idle = !stat_l.busy && !stat_r.busy;

    // The elapsed time saturates before it scales the per-millisecond step.
    assign ms_c = (ms_reg > 16'(ddmr_pkg::MAX_ELAPSED_MS))
                  ? ddmr_pkg::MS_W'(ddmr_pkg::MAX_ELAPSED_MS) : ms_reg[ddmr_pkg::MS_W-1:0];
    assign step   = rs_reg * ms_c;
    assign sl_eff = (sl_reg > ddmr_pkg::Q_ONE) ? ddmr_pkg::Q_ONE : sl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sl_reg   <= ddmr_pkg::Q_ONE;
            dz_reg   <= 15'd3277;
            ramp_reg <= 1'b1;
            rs_reg   <= 15'd98;
            invl_reg <= 1'b0;
            invr_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddmr_pkg::REG_SPEED_LIMIT: sl_reg   <= cfg_data;
                ddmr_pkg::REG_DEADZONE:    dz_reg   <= cfg_data[14:0];
                ddmr_pkg::REG_RAMP_ENABLE: ramp_reg <= cfg_data[0];
                ddmr_pkg::REG_RAMP_STEP:   rs_reg   <= cfg_data[14:0];
                ddmr_pkg::REG_INV_LEFT:    invl_reg <= cfg_data[0];
                ddmr_pkg::REG_INV_RIGHT:   invr_reg <= cfg_data[0];
                default:                   sl_reg   <= sl_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
            a_reg  <= value_a;
            b_reg  <= value_b;
            ms_reg <= elapsed_ms;
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            ddmr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ddmr_pkg::S_ISSUE;
                end
            end
            ddmr_pkg::S_ISSUE:
            begin
                second_next = 1'b0;
                if (op_reg == ddmr_pkg::OP_TANK || op_reg == ddmr_pkg::OP_ARCADE)
                begin
                    state_next = ddmr_pkg::S_DZ_WAIT;
                end
                else if (op_reg == ddmr_pkg::OP_STOP || ramp_reg)
                begin
                    state_next = ddmr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = ddmr_pkg::S_IDLE;
                end
            end
            ddmr_pkg::S_DZ_WAIT:
            begin
                if (lanes_idle)
                begin
                    if (op_reg == ddmr_pkg::OP_ARCADE && !second_reg)
                    begin
                        state_next = ddmr_pkg::S_NORM;
                    end
                    else
                    begin
                        state_next = ddmr_pkg::S_FIN;
                    end
                end
            end
            ddmr_pkg::S_NORM:
            begin
                state_next = ddmr_pkg::S_NORM_WAIT;
            end
            ddmr_pkg::S_NORM_WAIT:
            begin
                if (lanes_idle)
                begin
                    state_next = ddmr_pkg::S_DZ2;
                end
            end
            ddmr_pkg::S_DZ2:
            begin
                second_next = 1'b1;
                state_next  = ddmr_pkg::S_DZ_WAIT;
            end
            ddmr_pkg::S_FIN:
            begin
                state_next = ramp_reg ? ddmr_pkg::S_IDLE : ddmr_pkg::S_EMIT;
            end
            ddmr_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ddmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ddmr_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs and lane commands.
    always_comb
    begin
        cmd_l      = '0;
        cmd_l.op   = ddmr_pkg::LANE_NOP;
        cmd_l.dz   = dz_reg;
        cmd_l.sl   = sl_eff;
        cmd_l.inv  = invl_reg;
        cmd_l.ramp = ramp_reg;
        cmd_l.step = step;
        cmd_l.mx   = mix.mx;
        cmd_r      = cmd_l;
        cmd_r.inv  = invr_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ddmr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            ddmr_pkg::S_ISSUE:
            begin
                if (op_reg == ddmr_pkg::OP_TANK || op_reg == ddmr_pkg::OP_ARCADE)
                begin
                    cmd_l.op = ddmr_pkg::LANE_DZ;
                    cmd_r.op = ddmr_pkg::LANE_DZ;
                    cmd_l.x  = 18'(a_reg);
                    cmd_r.x  = 18'(b_reg);
                end
                else if (op_reg == ddmr_pkg::OP_STOP)
                begin
                    cmd_l.op = ddmr_pkg::LANE_STOP;
                    cmd_r.op = ddmr_pkg::LANE_STOP;
                end
                else if (ramp_reg)
                begin
                    cmd_l.op = ddmr_pkg::LANE_TICK;
                    cmd_r.op = ddmr_pkg::LANE_TICK;
                end
                else
                begin
                    cmd_l.op = ddmr_pkg::LANE_NOP;
                end
            end
            ddmr_pkg::S_NORM:
            begin
                cmd_l.op = ddmr_pkg::LANE_NORM;
                cmd_r.op = ddmr_pkg::LANE_NORM;
                cmd_l.x  = mix.sum;
                cmd_r.x  = mix.diff;
            end
            ddmr_pkg::S_DZ2:
            begin
                cmd_l.op = ddmr_pkg::LANE_DZ;
                cmd_r.op = ddmr_pkg::LANE_DZ;
                cmd_l.x  = stat_l.val;
                cmd_r.x  = stat_r.val;
            end
            ddmr_pkg::S_FIN:
            begin
                cmd_l.op = ddmr_pkg::LANE_FIN;
                cmd_r.op = ddmr_pkg::LANE_FIN;
            end
            ddmr_pkg::S_EMIT:
            begin
                load_out = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ddmr_pkg::S_IDLE;
            second_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            ov_reg     <= ov_next;
        end
    end

    // Output register: loads from the lanes' current values once the slot frees.
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rd_reg  <= stat_r.cur;
            ln_reg  <= -stat_l.cur;
            off_reg <= (op_reg == ddmr_pkg::OP_STOP);
        end
    end

    ddmr_lane u_lane_l (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_l),
        .stat  (stat_l)
    );

    ddmr_lane u_lane_r (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_r),
        .stat  (stat_r)
    );

    ddmr_merge u_merge (
        .stat_l (stat_l),
        .stat_r (stat_r),
        .mix    (mix)
    );

    assign out_valid          = ov_reg;
    assign right_drive        = rd_reg;
    assign left_drive_negated = ln_reg;
    assign motors_off         = off_reg;

endmodule

@@ rtl/ddmr_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmr_lane
// One wheel side: deadzone and normalize division, limit, invert and slew.
// ----------------------------------------------------------------------------
module ddmr_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ddmr_pkg::lane_cmd_t  cmd,
    output ddmr_pkg::lane_stat_t stat
);

    logic signed [15:0] cur_reg, cur_next;
    logic signed [15:0] tgt_reg, tgt_next;
    logic signed [17:0] val_reg, val_next;
    logic [17:0]        rem_reg, rem_next;
    logic [14:0]        q_reg, q_next;
    logic [16:0]        den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [ddmr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;

    logic [17:0] x_abs;
    logic [16:0] x_mag;
    logic        dz_below;
    logic [16:0] dz_diff;
    logic [16:0] dz_den;
    logic        dz_sat;
    logic        do_norm;
    logic        n_sat;
    logic signed [17:0] x_satv;
    logic [17:0] r2;
    logic        q_bit;
    logic [14:0] q_new;
    logic [17:0] v_abs;
    logic [30:0] prod;
    logic [14:0] lim;
    logic        lim_neg;
    logic signed [15:0] lim_s;
    logic signed [16:0] sdiff;
    logic [16:0] sdmag;
    logic signed [15:0] slewed;
    logic signed [17:0] sat_pos, sat_neg;

    assign sat_pos = 18'sd32767;
    assign sat_neg = -18'sd32767;

    always_comb
    begin
        x_abs    = cmd.x[17] ? -cmd.x : cmd.x;
        x_mag    = x_abs[16:0];
        dz_below = x_mag < {2'b0, cmd.dz};
        dz_diff  = x_mag - {2'b0, cmd.dz};
        dz_den   = {1'b0, ddmr_pkg::Q_ONE} - {2'b0, cmd.dz};
        dz_sat   = dz_diff >= dz_den;
        do_norm  = cmd.mx > {1'b0, ddmr_pkg::Q_ONE};
        n_sat    = x_mag >= cmd.mx;
        if (cmd.x > sat_pos)
        begin
            x_satv = sat_pos;
        end
        else if (cmd.x < sat_neg)
        begin
            x_satv = sat_neg;
        end
        else
        begin
            x_satv = cmd.x;
        end

        r2    = {rem_reg[16:0], 1'b0};
        q_bit = r2 >= {1'b0, den_reg};
        q_new = {q_reg[13:0], q_bit};

        v_abs   = val_reg[17] ? -val_reg : val_reg;
        prod    = v_abs[14:0] * cmd.sl;
        lim     = prod[29:15];
        lim_neg = val_reg[17] ^ cmd.inv;
        lim_s   = lim_neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});

        sdiff  = {tgt_reg[15], tgt_reg} - {cur_reg[15], cur_reg};
        sdmag  = sdiff[16] ? -sdiff : sdiff;
        if ({{(ddmr_pkg::STEP_W-17){1'b0}}, sdmag} <= cmd.step)
        begin
            slewed = tgt_reg;
        end
        else if (sdiff[16])
        begin
            slewed = cur_reg - $signed(cmd.step[15:0]);
        end
        else
        begin
            slewed = cur_reg + $signed(cmd.step[15:0]);
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            rem_next = q_bit ? r2 - {1'b0, den_reg} : r2;
            q_next   = q_new;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ddmr_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                val_next  = neg_reg ? -$signed({3'b0, q_new}) : $signed({3'b0, q_new});
            end
        end
        else
        begin
            case (cmd.op)
                ddmr_pkg::LANE_DZ:
                begin
                    if (dz_below)
                    begin
                        val_next = '0;
                    end
                    else if (dz_sat)
                    begin
                        val_next = cmd.x[17] ? sat_neg : sat_pos;
                    end
                    else
                    begin
                        rem_next  = {1'b0, dz_diff};
                        den_next  = dz_den;
                        neg_next  = cmd.x[17];
                        q_next    = '0;
                        cnt_next  = ddmr_pkg::CNT_W'(ddmr_pkg::DIV_STEPS);
                        busy_next = 1'b1;
                    end
                end
                ddmr_pkg::LANE_NORM:
                begin
                    if (!do_norm)
                    begin
                        val_next = x_satv;
                    end
                    else if (n_sat)
                    begin
                        val_next = cmd.x[17] ? sat_neg : sat_pos;
                    end
                    else
                    begin
                        rem_next  = {1'b0, x_mag};
                        den_next  = cmd.mx;
                        neg_next  = cmd.x[17];
                        q_next    = '0;
                        cnt_next  = ddmr_pkg::CNT_W'(ddmr_pkg::DIV_STEPS);
                        busy_next = 1'b1;
                    end
                end
                ddmr_pkg::LANE_FIN:
                begin
                    if (cmd.ramp)
                    begin
                        tgt_next = lim_s;
                    end
                    else
                    begin
                        cur_next = lim_s;
                    end
                end
                ddmr_pkg::LANE_TICK:
                begin
                    cur_next = slewed;
                end
                ddmr_pkg::LANE_STOP:
                begin
                    cur_next = '0;
                    tgt_next = '0;
                end
                default:
                begin
                    cur_next = cur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            tgt_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            tgt_reg  <= tgt_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.val  = val_reg;
    assign stat.cur  = cur_reg;

endmodule

@@ rtl/ddmr_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmr_merge
// Arcade mixing: sum and difference of the lanes and their larger magnitude.
// ----------------------------------------------------------------------------
module ddmr_merge (
    input  ddmr_pkg::lane_stat_t stat_l,
    input  ddmr_pkg::lane_stat_t stat_r,
    output ddmr_pkg::merge_t     mix
);

    logic [17:0] abs_s, abs_d;

    always_comb
    begin
        mix.sum  = stat_l.val + stat_r.val;
        mix.diff = stat_l.val - stat_r.val;
        abs_s    = mix.sum[17] ? -mix.sum : mix.sum;
        abs_d    = mix.diff[17] ? -mix.diff : mix.diff;
        mix.mx   = (abs_s > abs_d) ? abs_s[16:0] : abs_d[16:0];
    end

endmodule

@@ rtl/ddmr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmr_checker
// Port-level checks of the drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ddmr_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] right_drive,
    input logic signed [15:0] left_drive_negated,
    input logic               motors_off
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_drive)
            && $stable(left_drive_negated) && $stable(motors_off))
        else $error("stalled result changed");

    // A stop result drives both motors at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motors_off |-> right_drive == 16'sd0 && left_drive_negated == 16'sd0)
        else $error("stop result with nonzero drive");

    // Drives never reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_drive != -16'sd32768 && left_drive_negated != -16'sd32768)
        else $error("drive out of range");

    // One item is worked at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

endmodule

bind differential_drive_mixer_ramp ddmr_port_checks u_ddmr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .right_drive        (right_drive),
    .left_drive_negated (left_drive_negated),
    .motors_off         (motors_off)
);
